// ----- sv/trm_pkg.sv -----
package trm_pkg;

    localparam int ADDR_W = 9;
    localparam int WORD_W = 32;
    localparam int PORT_W = 8;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [1:0]        t_op;
    typedef logic [5:0]        t_opc;

    // item kinds
    localparam t_op OP_WRITE = 2'd0;
    localparam t_op OP_EXEC  = 2'd1;
    localparam t_op OP_READ  = 2'd2;

    localparam t_addr STACK_TOP_RESET = 9'd256;

    // instruction set
    localparam t_opc OPC_LDR  = 6'd0;
    localparam t_opc OPC_STR  = 6'd1;
    localparam t_opc OPC_MOV  = 6'd2;
    localparam t_opc OPC_MOVR = 6'd3;
    localparam t_opc OPC_PUSH = 6'd4;
    localparam t_opc OPC_POP  = 6'd5;
    localparam t_opc OPC_ADD  = 6'd6;
    localparam t_opc OPC_SUB  = 6'd7;
    localparam t_opc OPC_DIV  = 6'd8;
    localparam t_opc OPC_MUL  = 6'd9;
    localparam t_opc OPC_JMP  = 6'd10;
    localparam t_opc OPC_CALL = 6'd11;
    localparam t_opc OPC_CMP  = 6'd12;
    localparam t_opc OPC_JEQ  = 6'd13;
    localparam t_opc OPC_JNE  = 6'd14;
    localparam t_opc OPC_JG   = 6'd15;
    localparam t_opc OPC_JNG  = 6'd16;
    localparam t_opc OPC_JL   = 6'd17;
    localparam t_opc OPC_JLE  = 6'd18;
    localparam t_opc OPC_JGE  = 6'd19;
    localparam t_opc OPC_INB  = 6'd20;
    localparam t_opc OPC_OUTB = 6'd21;
    localparam t_opc OPC_HLT  = 6'd22;
    localparam t_opc OPC_ADDI = 6'd23;
    localparam t_opc OPC_SUBI = 6'd24;
    localparam t_opc OPC_DIVI = 6'd25;
    localparam t_opc OPC_MULI = 6'd26;
    localparam t_opc OPC_AND  = 6'd27;
    localparam t_opc OPC_ANDI = 6'd28;
    localparam t_opc OPC_OR   = 6'd29;
    localparam t_opc OPC_ORI  = 6'd30;
    localparam t_opc OPC_XOR  = 6'd31;
    localparam t_opc OPC_XORI = 6'd32;
    localparam t_opc OPC_NONE = 6'd63;

    typedef struct packed {
        t_word              read_data;
        t_addr              program_counter;
        logic               halted;
        logic               port_rd_strobe;
        logic               port_wr_strobe;
        logic [PORT_W-1:0]  port_number;
        t_word              port_write_data;
    } t_result;

endpackage

// ----- sv/trm_in_if.sv -----
interface trm_in_if;
    import trm_pkg::*;

    logic  valid;
    logic  ready;
    t_op   op;
    t_addr address;
    t_word data;
    t_word port_data_in;

    modport source (output valid, op, address, data, port_data_in, input ready);
    modport sink   (input valid, op, address, data, port_data_in, output ready);
endinterface

// ----- sv/trm_out_if.sv -----
interface trm_out_if;
    import trm_pkg::*;

    logic              valid;
    logic              ready;
    t_word             read_data;
    t_addr             program_counter;
    logic              halted;
    logic              port_rd_strobe;
    logic              port_wr_strobe;
    logic [PORT_W-1:0] port_number;
    t_word             port_write_data;

    modport source (output valid, read_data, program_counter, halted, port_rd_strobe,
                    port_wr_strobe, port_number, port_write_data, input ready);
    modport sink   (input valid, read_data, program_counter, halted, port_rd_strobe,
                    port_wr_strobe, port_number, port_write_data, output ready);
endinterface

// ----- sv/tiny_register_machine_core.sv -----
// tiny register machine: each execute transfer runs one whole instruction from
// word memory (opcode word then operand words, fetched one a cycle through the
// single read port of the word memory), write and read transfers load and
// inspect that memory. one item is in flight at a time and a new transfer is
// taken once the previous result has been taken. the time an instruction takes
// is set by its word fetches and register-file reads (one port each), and a
// divide runs longest because its quotient is formed one bit a cycle. MEM_DEPTH
// and NUM_REGS are powers of two; the word memory has no reset and the register
// file reads as zero until written.
module tiny_register_machine_core #(
    parameter int MEM_DEPTH = 512,
    parameter int NUM_REGS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  trm_pkg::t_addr       i_cfg_wr_data,
    trm_in_if.sink               i_in,
    trm_out_if.source            o_out
);
    import trm_pkg::*;

    localparam int AW = $clog2(MEM_DEPTH);
    localparam int RW = $clog2(NUM_REGS);

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_READ = 4'd1;
    localparam logic [3:0] ST_OPC  = 4'd2;
    localparam logic [3:0] ST_W1   = 4'd3;
    localparam logic [3:0] ST_W2   = 4'd4;
    localparam logic [3:0] ST_W3   = 4'd5;
    localparam logic [3:0] ST_CMPA = 4'd6;
    localparam logic [3:0] ST_ALUB = 4'd7;
    localparam logic [3:0] ST_ALU  = 4'd8;
    localparam logic [3:0] ST_EXEC = 4'd9;
    localparam logic [3:0] ST_DIV  = 4'd10;
    localparam logic [3:0] ST_DIVW = 4'd11;

    // storage
    t_word              r_mem [MEM_DEPTH];
    t_word              r_rf  [NUM_REGS];
    logic [NUM_REGS-1:0] r_rf_vld;
    t_word              r_mem_q;
    t_word              r_rf_q;
    logic               r_rf_v;

    // architectural state
    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_pc, n_pc;
    logic [AW-1:0] r_sp, n_sp;
    logic [AW-1:0] r_ra, n_ra;
    logic          r_eq, n_eq, r_gt, n_gt, r_lt, n_lt;
    logic          r_halt, n_halt;

    // per-instruction scratch
    t_opc  r_opc, n_opc;
    t_word r_w1, n_w1, r_w2, n_w2, r_a, n_a, r_b, n_b, r_pin, n_pin;

    // divider
    logic [4:0] r_div_cnt, n_div_cnt;
    t_word      r_rem, n_rem, r_quo, n_quo, r_dvs, n_dvs;
    logic       r_dneg, n_dneg;

    // result register
    logic    r_ovalid;
    t_result r_out, n_out;

    // memory and register-file access
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    t_word         mem_wd;
    logic          rf_we;
    logic [RW-1:0] rf_wa, rf_ra;
    t_word         rf_wd;

    logic  accept, fin, take, imm;
    t_word rfval, abs_a, abs_b;
    logic [32:0] rem_sh, rem_diff;

    assign i_in.ready = (r_state == ST_IDLE) && !r_ovalid;
    assign accept     = i_in.valid && i_in.ready;
    assign rfval      = r_rf_v ? r_rf_q : '0;

    assign abs_a    = r_a[31] ? (~r_a + 32'd1) : r_a;
    assign abs_b    = r_b[31] ? (~r_b + 32'd1) : r_b;
    assign rem_sh   = {r_rem, r_quo[31]};
    assign rem_diff = rem_sh - {1'b0, r_dvs};

    assign imm      = (r_opc >= OPC_ADDI) && ((r_opc <= OPC_MULI) || !r_opc[0]);

    always_comb begin
        case (r_opc)
            OPC_JEQ: take = r_eq;
            OPC_JNE: take = !r_eq;
            OPC_JG:  take = r_gt;
            OPC_JNG: take = !r_gt;
            OPC_JL:  take = r_lt;
            OPC_JLE: take = r_lt || r_eq;
            OPC_JGE: take = r_gt || r_eq;
            default: take = 1'b1;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_pc      = r_pc;
        n_sp      = r_sp;
        n_ra      = r_ra;
        n_eq      = r_eq;
        n_gt      = r_gt;
        n_lt      = r_lt;
        n_halt    = r_halt;
        n_opc     = r_opc;
        n_w1      = r_w1;
        n_w2      = r_w2;
        n_a       = r_a;
        n_b       = r_b;
        n_pin     = r_pin;
        n_div_cnt = r_div_cnt;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_dvs     = r_dvs;
        n_dneg    = r_dneg;
        mem_we    = 1'b0;
        mem_wa    = '0;
        mem_wd    = '0;
        mem_ra    = r_pc;
        rf_we     = 1'b0;
        rf_wa     = '0;
        rf_wd     = '0;
        rf_ra     = '0;
        fin       = 1'b0;
        n_out     = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_pin = i_in.port_data_in;
                    case (i_in.op)
                        OP_WRITE: begin
                            mem_we = 1'b1;
                            mem_wa = AW'(i_in.address);
                            mem_wd = i_in.data;
                            fin    = 1'b1;
                        end
                        OP_READ: begin
                            mem_ra  = AW'(i_in.address);
                            n_state = ST_READ;
                        end
                        OP_EXEC: begin
                            if (r_halt) begin
                                fin = 1'b1;
                            end else begin
                                n_pc    = r_pc + 1'b1;
                                n_state = ST_OPC;
                            end
                        end
                        default: fin = 1'b1;
                    endcase
                end
            end
            ST_READ: begin
                fin             = 1'b1;
                n_out.read_data = r_mem_q;
            end
            ST_OPC: begin
                n_opc = (r_mem_q <= 32'(OPC_XORI)) ? t_opc'(r_mem_q) : OPC_NONE;
                if (r_mem_q == 32'(OPC_HLT)) begin
                    n_halt = 1'b1;
                    fin    = 1'b1;
                end else if (r_mem_q > 32'(OPC_XORI)) begin
                    fin = 1'b1;
                end else begin
                    // return address is the call's offset word address plus two
                    if (r_mem_q == 32'(OPC_CALL)) n_ra = r_pc + AW'(2);
                    n_pc    = r_pc + 1'b1;
                    n_state = ST_W1;
                end
            end
            ST_W1: begin
                n_w1 = r_mem_q;
                case (r_opc)
                    OPC_PUSH: begin
                        rf_ra   = RW'(r_mem_q);
                        n_state = ST_EXEC;
                    end
                    OPC_POP: begin
                        n_sp    = r_sp + 1'b1;
                        mem_ra  = r_sp + 1'b1;
                        n_state = ST_EXEC;
                    end
                    OPC_JMP, OPC_CALL, OPC_JEQ, OPC_JNE, OPC_JG, OPC_JNG,
                    OPC_JL, OPC_JLE, OPC_JGE: begin
                        if (take) n_pc = r_pc + AW'(r_mem_q);
                        fin = 1'b1;
                    end
                    default: begin
                        n_pc    = r_pc + 1'b1;
                        n_state = ST_W2;
                    end
                endcase
            end
            ST_W2: begin
                n_w2    = r_mem_q;
                n_state = ST_EXEC;
                case (r_opc)
                    OPC_LDR: begin
                        rf_we   = 1'b1;
                        rf_wa   = RW'(r_w1);
                        rf_wd   = r_mem_q;
                        fin     = 1'b1;
                    end
                    OPC_STR, OPC_MOVR: rf_ra = RW'(r_mem_q);
                    OPC_MOV:  mem_ra = AW'(r_mem_q);
                    OPC_OUTB: rf_ra  = RW'(r_w1);
                    OPC_CMP: begin
                        rf_ra   = RW'(r_w1);
                        n_state = ST_CMPA;
                    end
                    OPC_INB: begin
                        rf_we                  = 1'b1;
                        rf_wa                  = RW'(r_w1);
                        rf_wd                  = r_pin;
                        fin                    = 1'b1;
                        n_out.port_rd_strobe   = 1'b1;
                        n_out.port_number      = r_mem_q[PORT_W-1:0];
                    end
                    default: begin
                        // arithmetic: first source now, third word next
                        rf_ra   = RW'(r_mem_q);
                        n_pc    = r_pc + 1'b1;
                        n_state = ST_W3;
                    end
                endcase
            end
            ST_W3: begin
                n_a = rfval;
                if (imm) begin
                    n_b     = r_mem_q;
                    n_state = ST_ALU;
                end else begin
                    rf_ra   = RW'(r_mem_q);
                    n_state = ST_ALUB;
                end
            end
            ST_ALUB: begin
                n_b     = rfval;
                n_state = ST_ALU;
            end
            ST_ALU: begin
                rf_wa = RW'(r_w1);
                if ((r_opc == OPC_DIV) || (r_opc == OPC_DIVI)) begin
                    if (r_b == '0) begin
                        rf_we = 1'b1;
                        fin   = 1'b1;
                    end else begin
                        n_rem     = '0;
                        n_quo     = abs_a;
                        n_dvs     = abs_b;
                        n_dneg    = r_a[31] ^ r_b[31];
                        n_div_cnt = 5'd31;
                        n_state   = ST_DIV;
                    end
                end else begin
                    rf_we = 1'b1;
                    fin   = 1'b1;
                    case (r_opc)
                        OPC_ADD, OPC_ADDI: rf_wd = r_a + r_b;
                        OPC_SUB, OPC_SUBI: rf_wd = r_a - r_b;
                        OPC_MUL, OPC_MULI: rf_wd = r_a * r_b;
                        OPC_AND, OPC_ANDI: rf_wd = r_a & r_b;
                        OPC_OR,  OPC_ORI:  rf_wd = r_a | r_b;
                        default:           rf_wd = r_a ^ r_b;
                    endcase
                end
            end
            ST_DIV: begin
                // restoring step on magnitudes, one quotient bit a cycle
                n_rem = rem_diff[32] ? rem_sh[31:0] : rem_diff[31:0];
                n_quo = {r_quo[30:0], !rem_diff[32]};
                if (r_div_cnt == '0) n_state = ST_DIVW;
                else n_div_cnt = r_div_cnt - 1'b1;
            end
            ST_DIVW: begin
                rf_we = 1'b1;
                rf_wa = RW'(r_w1);
                rf_wd = r_dneg ? (~r_quo + 32'd1) : r_quo;
                fin   = 1'b1;
            end
            ST_CMPA: begin
                n_a     = rfval;
                rf_ra   = RW'(r_w2);
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                fin = 1'b1;
                case (r_opc)
                    OPC_STR: begin
                        mem_we = 1'b1;
                        mem_wa = AW'(r_w1);
                        mem_wd = rfval;
                    end
                    OPC_MOV: begin
                        mem_we = 1'b1;
                        mem_wa = AW'(r_w1);
                        mem_wd = r_mem_q;
                    end
                    OPC_MOVR: begin
                        rf_we = 1'b1;
                        rf_wa = RW'(r_w1);
                        rf_wd = rfval;
                    end
                    OPC_PUSH: begin
                        mem_we = 1'b1;
                        mem_wa = r_sp;
                        mem_wd = rfval;
                        n_sp   = r_sp - 1'b1;
                    end
                    OPC_POP: begin
                        rf_we = 1'b1;
                        rf_wa = RW'(r_w1);
                        rf_wd = r_mem_q;
                    end
                    OPC_CMP: begin
                        n_eq = (r_a == rfval);
                        n_gt = ($signed(r_a) > $signed(rfval));
                        n_lt = ($signed(r_a) < $signed(rfval));
                    end
                    OPC_OUTB: begin
                        n_out.port_wr_strobe  = 1'b1;
                        n_out.port_number     = r_w2[PORT_W-1:0];
                        n_out.port_write_data = rfval;
                    end
                    default: ;
                endcase
            end
            default: n_state = ST_IDLE;
        endcase

        if (fin) n_state = ST_IDLE;
        n_out.program_counter = ADDR_W'(n_pc);
        n_out.halted          = n_halt;

        // the user must write the stack top only while idle; the block does not enforce it
        if (i_cfg_wr_en) n_sp = AW'(i_cfg_wr_data);
    end

    // word memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_mem_q <= r_mem[mem_ra];
    end

    // register file, zero until first written
    always_ff @(posedge i_clk) begin
        if (rf_we) r_rf[rf_wa] <= rf_wd;
        r_rf_q <= r_rf[rf_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
            r_rf_v   <= 1'b0;
        end else begin
            if (rf_we) r_rf_vld[rf_wa] <= 1'b1;
            r_rf_v <= r_rf_vld[rf_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pc     <= '0;
            r_sp     <= AW'(STACK_TOP_RESET);
            r_ra     <= '0;
            r_eq     <= 1'b0;
            r_gt     <= 1'b0;
            r_lt     <= 1'b0;
            r_halt   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_sp    <= n_sp;
            r_ra    <= n_ra;
            r_eq    <= n_eq;
            r_gt    <= n_gt;
            r_lt    <= n_lt;
            r_halt  <= n_halt;
            if (fin) r_ovalid <= 1'b1;
            else if (o_out.ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opc     <= n_opc;
        r_w1      <= n_w1;
        r_w2      <= n_w2;
        r_a       <= n_a;
        r_b       <= n_b;
        r_pin     <= n_pin;
        r_div_cnt <= n_div_cnt;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_dvs     <= n_dvs;
        r_dneg    <= n_dneg;
        if (fin) r_out <= n_out;
    end

    assign o_out.valid           = r_ovalid;
    assign o_out.read_data       = r_out.read_data;
    assign o_out.program_counter = r_out.program_counter;
    assign o_out.halted          = r_out.halted;
    assign o_out.port_rd_strobe  = r_out.port_rd_strobe;
    assign o_out.port_wr_strobe  = r_out.port_wr_strobe;
    assign o_out.port_number     = r_out.port_number;
    assign o_out.port_write_data = r_out.port_write_data;

    // a held result always parks the sequencer
    a_result_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_state == ST_IDLE))
        else $error("result held while sequencer busy");

    // only reset leaves the halted state
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag dropped");

    // one instruction never writes both stores in one cycle
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && rf_we))
        else $error("memory and register file written together");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import trm_pkg::*;

    // item kind with no defined meaning: only pc and halted come back
    localparam t_op   OP_SPARE    = 2'd3;
    localparam int    MEM_WORDS   = 512;
    localparam int    CYCLE_LIMIT = 600000;
    localparam t_word INT_MIN     = 32'h8000_0000;
    localparam t_word INT_MAX     = 32'h7fff_ffff;

    // machine predictor and the queue of results it expects
    class exec_scoreboard;
        t_word   mem [MEM_WORDS];
        t_word   regs [16];
        t_addr   pc, sp, ret_addr;
        bit      eq_f, gt_f, lt_f, halt_f;
        t_result expected_q [$];
        int      errors;

        function new();
            foreach (mem[i]) mem[i] = '0;
            foreach (regs[i]) regs[i] = '0;
            pc = '0;
            sp = STACK_TOP_RESET;
            ret_addr = '0;
            {eq_f, gt_f, lt_f, halt_f} = '0;
            errors = 0;
        endfunction

        function void set_stack_top(t_addr v);
            sp = v;
        endfunction

        function t_word fetch();
            fetch = mem[pc];
            pc = pc + 1'b1;
        endfunction

        function void cond_jump(bit take);
            t_word off;
            off = fetch();
            if (take) pc = pc + off[8:0];
        endfunction

        function t_word quotient(t_word a, t_word b);
            if (b == '0) return '0;
            if (a == INT_MIN && b == '1) return a;
            return $signed(a) / $signed(b);
        endfunction

        function void note_input(t_op op, t_addr addr, t_word data, t_word pin);
            t_result r;
            t_word   opc, a, b, w;
            t_addr   m;
            logic [3:0] d;
            bit      imm;
            r = '0;
            if (op == OP_WRITE) begin
                mem[addr] = data;
            end else if (op == OP_READ) begin
                r.read_data = mem[addr];
            end else if (op == OP_EXEC && !halt_f) begin
                opc = fetch();
                case (opc)
                    OPC_LDR: begin
                        d = 4'(fetch());
                        regs[d] = fetch();
                    end
                    OPC_STR: begin
                        m = 9'(fetch());
                        mem[m] = regs[4'(fetch())];
                    end
                    OPC_MOV: begin
                        m = 9'(fetch());
                        w = mem[9'(fetch())];
                        mem[m] = w;
                    end
                    OPC_MOVR: begin
                        d = 4'(fetch());
                        regs[d] = regs[4'(fetch())];
                    end
                    OPC_PUSH: begin
                        mem[sp] = regs[4'(fetch())];
                        sp = sp - 1'b1;
                    end
                    OPC_POP: begin
                        d = 4'(fetch());
                        sp = sp + 1'b1;
                        regs[d] = mem[sp];
                    end
                    OPC_JMP: cond_jump(1'b1);
                    OPC_CALL: begin
                        ret_addr = pc + 9'd2;
                        cond_jump(1'b1);
                    end
                    OPC_CMP: begin
                        a = regs[4'(fetch())];
                        b = regs[4'(fetch())];
                        eq_f = (a == b);
                        gt_f = ($signed(a) > $signed(b));
                        lt_f = ($signed(a) < $signed(b));
                    end
                    OPC_JEQ: cond_jump(eq_f);
                    OPC_JNE: cond_jump(!eq_f);
                    OPC_JG:  cond_jump(gt_f);
                    OPC_JNG: cond_jump(!gt_f);
                    OPC_JL:  cond_jump(lt_f);
                    OPC_JLE: cond_jump(lt_f || eq_f);
                    OPC_JGE: cond_jump(gt_f || eq_f);
                    OPC_INB: begin
                        d = 4'(fetch());
                        r.port_number = 8'(fetch());
                        regs[d] = pin;
                        r.port_rd_strobe = 1'b1;
                    end
                    OPC_OUTB: begin
                        r.port_write_data = regs[4'(fetch())];
                        r.port_number = 8'(fetch());
                        r.port_wr_strobe = 1'b1;
                    end
                    OPC_HLT: halt_f = 1'b1;
                    OPC_ADD, OPC_SUB, OPC_DIV, OPC_MUL, OPC_ADDI, OPC_SUBI, OPC_DIVI,
                    OPC_MULI, OPC_AND, OPC_ANDI, OPC_OR, OPC_ORI, OPC_XOR, OPC_XORI: begin
                        d = 4'(fetch());
                        a = regs[4'(fetch())];
                        w = fetch();
                        imm = (opc >= OPC_ADDI) && (opc <= OPC_MULI || !opc[0]);
                        b = imm ? w : regs[w[3:0]];
                        case (opc)
                            OPC_ADD, OPC_ADDI: regs[d] = a + b;
                            OPC_SUB, OPC_SUBI: regs[d] = a - b;
                            OPC_DIV, OPC_DIVI: regs[d] = quotient(a, b);
                            OPC_MUL, OPC_MULI: regs[d] = a * b;
                            OPC_AND, OPC_ANDI: regs[d] = a & b;
                            OPC_OR, OPC_ORI:   regs[d] = a | b;
                            default:           regs[d] = a ^ b;
                        endcase
                    end
                    default: ;
                endcase
            end
            r.program_counter = pc;
            r.halted = halt_f;
            expected_q.push_back(r);
        endfunction

        function void compare(string field, t_word want, t_word got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            compare("read_data", want.read_data, got.read_data);
            compare("program_counter", t_word'(want.program_counter),
                    t_word'(got.program_counter));
            compare("halted", t_word'(want.halted), t_word'(got.halted));
            compare("port_rd_strobe", t_word'(want.port_rd_strobe),
                    t_word'(got.port_rd_strobe));
            compare("port_wr_strobe", t_word'(want.port_wr_strobe),
                    t_word'(got.port_wr_strobe));
            compare("port_number", t_word'(want.port_number), t_word'(got.port_number));
            compare("port_write_data", want.port_write_data, got.port_write_data);
        endfunction
    endclass

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  cfg_wr_en;
    t_addr cfg_wr_data;

    trm_in_if  in_if ();
    trm_out_if out_if ();

    exec_scoreboard sb = new();

    int cycles   = 0;
    int n_items  = 0;
    bit quiet    = 1'b0;  // no idling on either side while set
    bit hold_req = 1'b0;  // asks the receiver for one long hold-off
    int hold_left = 0;

    always #6 i_clk = ~i_clk;

    tiny_register_machine_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_if),
        .o_out         (out_if)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom % 100;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // receiving side: checks every result transfer and stalls at random
    initial begin
        t_result got;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                got.read_data       = out_if.read_data;
                got.program_counter = out_if.program_counter;
                got.halted          = out_if.halted;
                got.port_rd_strobe  = out_if.port_rd_strobe;
                got.port_wr_strobe  = out_if.port_wr_strobe;
                got.port_number     = out_if.port_number;
                got.port_write_data = out_if.port_write_data;
                sb.check_result(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (hold_req) begin
                // long hold-off while the sender keeps offering
                hold_req = 1'b0;
                hold_left = 199;
                out_if.ready <= 1'b0;
            end else if (quiet || $urandom % 100 < 70) begin
                out_if.ready <= 1'b1;
            end else begin
                hold_left = pick_gap();
                out_if.ready <= 1'b0;
            end
        end
    end

    // one input transfer; valid stays high when the next item follows at once
    task automatic send(t_op op, t_addr addr, t_word data, t_word pin);
        int g;
        g = pick_gap();
        if (g > 0) begin
            in_if.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.op           <= op;
        in_if.address      <= addr;
        in_if.data         <= data;
        in_if.port_data_in <= pin;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_input(op, addr, data, pin);
        n_items++;
    endtask

    // sender pauses until every expected result has been taken
    task automatic drain();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_q.size() != 0);
    endtask

    task automatic write_stack_top(t_addr v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        sb.set_stack_top(v);
        cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_word pick_operand();
        case ($urandom % 6)
            0, 1:    return $urandom_range(0, 15);
            2:       return $urandom;
            3: begin
                case ($urandom % 5)
                    0:       return '0;
                    1:       return 32'd1;
                    2:       return '1;
                    3:       return INT_MIN;
                    default: return INT_MAX;
                endcase
            end
            4:       return $urandom_range(0, 511);
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    function automatic int operand_count(t_word opc);
        case (opc)
            OPC_LDR, OPC_STR, OPC_MOV, OPC_MOVR, OPC_CMP, OPC_INB, OPC_OUTB: return 2;
            OPC_PUSH, OPC_POP, OPC_JMP, OPC_CALL, OPC_JEQ, OPC_JNE, OPC_JG, OPC_JNG,
            OPC_JL, OPC_JLE, OPC_JGE: return 1;
            OPC_HLT: return 0;
            default: return (opc <= OPC_XORI) ? 3 : 0;
        endcase
    endfunction

    // lay down one instruction at pc and execute it
    task automatic run_instr(t_word opc, t_word w0, t_word w1, t_word w2);
        t_addr base;
        t_word ops [3];
        int    n;
        base = sb.pc;
        ops = '{w0, w1, w2};
        n = operand_count(opc);
        send(OP_WRITE, base, opc, $urandom);
        for (int i = 0; i < n; i++) send(OP_WRITE, base + t_addr'(i + 1), ops[i], $urandom);
        send(OP_EXEC, t_addr'($urandom), $urandom, $urandom);
    endtask

    function automatic t_word pick_opcode();
        t_word opc;
        if ($urandom % 20 == 0) return ($urandom % 2) ? $urandom : $urandom_range(33, 63);
        do opc = $urandom_range(0, 32); while (opc == OPC_HLT);
        return opc;
    endfunction

    // execute whatever lies at pc, keeping halt out until the last phase
    task automatic run_plain(bit halt_ok);
        if (!halt_ok && sb.mem[sb.pc] == OPC_HLT)
            send(OP_WRITE, sb.pc, t_word'(OPC_NONE), $urandom);
        send(OP_EXEC, t_addr'($urandom), $urandom, $urandom);
    endtask

    task automatic random_items(int count);
        int stop_at, r;
        stop_at = n_items + count;
        while (n_items < stop_at) begin
            if ($urandom % 40 == 0) quiet = !quiet;
            r = $urandom % 100;
            if (r < 50)      run_instr(pick_opcode(), pick_operand(), pick_operand(),
                                       pick_operand());
            else if (r < 70) run_plain(1'b0);
            else if (r < 82) send(OP_WRITE, t_addr'($urandom), ($urandom % 2) ? pick_opcode()
                                                                   : $urandom, $urandom);
            else if (r < 96) send(OP_READ, t_addr'($urandom), $urandom, $urandom);
            else             send(OP_SPARE, t_addr'($urandom), $urandom, $urandom);
        end
        quiet = 1'b0;
    endtask

    initial begin
        in_if.valid        <= 1'b0;
        in_if.op           <= OP_WRITE;
        in_if.address      <= '0;
        in_if.data         <= '0;
        in_if.port_data_in <= '0;
        cfg_wr_en          <= 1'b0;
        cfg_wr_data        <= '0;
        i_rst_n            <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the whole memory so no fetch ever reads an unwritten word
        for (int i = 0; i < MEM_WORDS; i++)
            send(OP_WRITE, t_addr'(i), ($urandom % 2) ? pick_opcode() : pick_operand(),
                 $urandom);

        // corner cases: signed extremes, overflowing and zero divide, flags
        run_instr(t_word'(OPC_LDR), 15, INT_MIN, 0);
        run_instr(t_word'(OPC_LDR), 32'hffff_fff1, '1, 0);  // register index wraps to 1
        run_instr(t_word'(OPC_LDR), 0, INT_MAX, 0);
        run_instr(t_word'(OPC_DIV), 2, 15, 1);
        run_instr(t_word'(OPC_DIVI), 3, 15, 0);
        run_instr(t_word'(OPC_CMP), 15, 1, 0);
        run_instr(t_word'(OPC_JL), 32'hffff_fff0, 0, 0);
        run_instr(t_word'(OPC_CMP), 0, 0, 0);
        run_instr(t_word'(OPC_JNE), 7, 0, 0);               // untaken, skips its offset
        run_instr('1, 0, 0, 0);                             // unknown opcode
        run_instr(t_word'(OPC_INB), 7, 32'h0000_01ff, 0);
        run_instr(t_word'(OPC_OUTB), 15, 255, 0);
        send(OP_SPARE, '1, '1, '1);
        send(OP_READ, 9'd511, '0, '0);

        random_items(100);
        write_stack_top(9'd0);
        hold_req = 1'b1;
        random_items(100);
        write_stack_top(9'd511);
        random_items(50);
        drain();
        random_items(50);
        write_stack_top(t_addr'($urandom));
        random_items(100);
        write_stack_top(STACK_TOP_RESET);
        random_items(40);

        // halted machine: execute does nothing, memory access still works
        run_instr(t_word'(OPC_HLT), 0, 0, 0);
        for (int i = 0; i < 4; i++) run_plain(1'b1);
        send(OP_WRITE, t_addr'($urandom), $urandom, $urandom);
        send(OP_READ, t_addr'($urandom), $urandom, $urandom);
        run_plain(1'b1);

        drain();
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/trm_pkg.sv
sv/trm_in_if.sv
sv/trm_out_if.sv
sv/tiny_register_machine_core.sv
tb/testbench.sv
